// ===== design/hjd_pkg.sv =====
package hjd_pkg;

  // default width of the job and settle timers
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int NJOBS = 5;
  localparam int DELAY_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // job codes, also their priority order
  localparam logic [2:0] JOB_REMOVE  = 3'd0;
  localparam logic [2:0] JOB_INSERT  = 3'd1;
  localparam logic [2:0] JOB_KEYEN   = 3'd2;
  localparam logic [2:0] JOB_PRESS   = 3'd3;
  localparam logic [2:0] JOB_RELEASE = 3'd4;

  // jack state codes
  localparam logic [1:0] JS_NONE    = 2'd0;
  localparam logic [1:0] JS_HEADSET = 2'd1;
  localparam logic [1:0] JS_NO_MIC  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DETECT_DELAY  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE_DELAY  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEYEN_DELAY   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESS_DELAY   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE_DELAY = 3'd4;

  localparam logic [DELAY_WIDTH-1:0] DETECT_DELAY_RST  = 16'd20;
  localparam logic [DELAY_WIDTH-1:0] SETTLE_DELAY_RST  = 16'd10;
  localparam logic [DELAY_WIDTH-1:0] KEYEN_DELAY_RST   = 16'd600;
  localparam logic [DELAY_WIDTH-1:0] PRESS_DELAY_RST   = 16'd200;
  localparam logic [DELAY_WIDTH-1:0] RELEASE_DELAY_RST = 16'd200;

  typedef struct packed {
    logic jack_removed;
    logic three_pole;
    logic key_level;
  } sample_t;

  typedef struct packed {
    logic [1:0] jack_state;
    logic       mic_enable;
    logic       mic_bias;
    logic       headphone_event;
    logic       headphone_value;
    logic       mic_event;
    logic       mic_value;
    logic       key_event;
    logic       key_value;
  } report_t;

  typedef struct packed {
    logic [DELAY_WIDTH-1:0] detect_delay;
    logic [DELAY_WIDTH-1:0] pole_settle_delay;
    logic [DELAY_WIDTH-1:0] key_enable_delay;
    logic [DELAY_WIDTH-1:0] press_delay;
    logic [DELAY_WIDTH-1:0] release_delay;
  } delays_t;

endpackage

// ===== design/hjd_core.sv =====
module hjd_core #(
  parameter int TIMER_WIDTH = hjd_pkg::TIMER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  hjd_pkg::sample_t sample,
  input  hjd_pkg::delays_t delays,
  output hjd_pkg::report_t report
);
  import hjd_pkg::*;

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  localparam logic [31:0] TMAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  // saturate a 16-bit delay into the timer width
  function automatic tmr_t clip(input logic [DELAY_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > TMAX32) ? TMAX32[TIMER_WIDTH-1:0] : w[TIMER_WIDTH-1:0];
  endfunction

  logic             last_detect, last_detect_next;
  logic             last_key, last_key_next;
  logic [NJOBS-1:0] job_pending, job_pending_next;
  tmr_t             job_timer [NJOBS];
  tmr_t             job_timer_next [NJOBS];
  logic             settle_active, settle_active_next;
  tmr_t             settle_timer, settle_timer_next;
  logic             key_watch, key_watch_next;
  logic             button_down, button_down_next;
  logic [1:0]       device_state, device_state_next;
  logic             mic_enable_reg, mic_enable_next;
  logic             mic_bias_reg, mic_bias_next;
  logic             run_valid;
  logic [2:0]       run_job;
  report_t          rep;

  always_comb begin
    last_detect_next = sample.jack_removed;
    last_key_next    = sample.key_level;
    job_pending_next = job_pending;
    job_timer_next   = job_timer;
    settle_active_next = settle_active;
    settle_timer_next  = settle_timer;
    key_watch_next     = key_watch;
    button_down_next   = button_down;
    device_state_next  = device_state;
    mic_enable_next    = mic_enable_reg;
    mic_bias_next      = mic_bias_reg;
    rep     = '0;
    run_valid = 1'b0;
    run_job   = JOB_REMOVE;

    // jack detect edges
    if (sample.jack_removed != last_detect) begin
      if (sample.jack_removed) begin
        job_pending_next[JOB_INSERT] = 1'b0;
        if (!job_pending_next[JOB_REMOVE]) begin
          job_pending_next[JOB_REMOVE] = 1'b1;
          job_timer_next[JOB_REMOVE]   = clip(delays.detect_delay);
        end
      end else if (!job_pending_next[JOB_INSERT]) begin
        job_pending_next[JOB_INSERT] = 1'b1;
        job_timer_next[JOB_INSERT]   = clip(delays.detect_delay);
      end
    end

    // hook key edges
    if (sample.key_level != last_key && key_watch) begin
      if (sample.key_level) begin
        if (!job_pending_next[JOB_PRESS]) begin
          job_pending_next[JOB_PRESS] = 1'b1;
          job_timer_next[JOB_PRESS]   = clip(delays.press_delay);
        end
      end else if (!job_pending_next[JOB_RELEASE]) begin
        job_pending_next[JOB_RELEASE] = 1'b1;
        job_timer_next[JOB_RELEASE]   = clip(delays.release_delay);
      end
    end

    if (settle_active) begin
      if (settle_timer == '0) begin
        settle_active_next  = 1'b0;
        rep.headphone_event = 1'b1;
        rep.headphone_value = 1'b1;
        if (sample.three_pole) begin
          mic_bias_next     = 1'b0;
          device_state_next = JS_NO_MIC;
        end else begin
          job_pending_next[JOB_KEYEN] = 1'b1;
          job_timer_next[JOB_KEYEN]   = clip(delays.key_enable_delay);
          device_state_next = JS_HEADSET;
          rep.mic_event     = 1'b1;
          rep.mic_value     = 1'b1;
        end
      end
    end else begin
      // lowest expired job wins
      for (int i = NJOBS - 1; i >= 0; i--) begin
        if (job_pending_next[i] && job_timer_next[i] == '0) begin
          run_valid = 1'b1;
          run_job   = 3'(i);
        end
      end
    end

    if (run_valid) begin
      job_pending_next[run_job] = 1'b0;
      case (run_job)
        JOB_REMOVE: begin
          if (sample.jack_removed) begin
            device_state_next = JS_NONE;
            mic_enable_next   = 1'b0;
            mic_bias_next     = 1'b0;
            key_watch_next    = 1'b0;
            if (button_down) begin
              rep.key_event    = 1'b1;
              button_down_next = 1'b0;
            end
            rep.headphone_event = 1'b1;
            if (device_state == JS_HEADSET) begin
              rep.mic_event = 1'b1;
            end
          end
        end
        JOB_INSERT: begin
          if (!sample.jack_removed) begin
            mic_bias_next      = 1'b1;
            mic_enable_next    = 1'b1;
            settle_active_next = 1'b1;
            settle_timer_next  = clip(delays.pole_settle_delay);
          end
        end
        JOB_KEYEN: begin
          if (!sample.jack_removed && !key_watch) begin
            key_watch_next   = 1'b1;
            button_down_next = 1'b0;
          end
        end
        JOB_PRESS: begin
          if (!sample.jack_removed && device_state == JS_HEADSET && !button_down) begin
            button_down_next = 1'b1;
            rep.key_event    = 1'b1;
            rep.key_value    = 1'b1;
          end
        end
        JOB_RELEASE: begin
          if (!sample.jack_removed && device_state == JS_HEADSET && button_down) begin
            button_down_next = 1'b0;
            rep.key_event    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // count down
    for (int i = 0; i < NJOBS; i++) begin
      if (job_pending_next[i] && job_timer_next[i] != '0) begin
        job_timer_next[i] = job_timer_next[i] - tmr_t'(1);
      end
    end
    if (settle_active_next && settle_timer_next != '0) begin
      settle_timer_next = settle_timer_next - tmr_t'(1);
    end

    rep.jack_state = device_state_next;
    rep.mic_enable = mic_enable_next;
    rep.mic_bias   = mic_bias_next;
  end

  assign report = rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_detect    <= 1'b1;
      last_key       <= 1'b0;
      job_pending    <= '0;
      settle_active  <= 1'b0;
      settle_timer   <= '0;
      key_watch      <= 1'b0;
      button_down    <= 1'b0;
      device_state   <= JS_NONE;
      mic_enable_reg <= 1'b0;
      mic_bias_reg   <= 1'b0;
      for (int i = 0; i < NJOBS; i++) begin
        job_timer[i] <= '0;
      end
    end else if (step) begin
      last_detect    <= last_detect_next;
      last_key       <= last_key_next;
      job_pending    <= job_pending_next;
      job_timer      <= job_timer_next;
      settle_active  <= settle_active_next;
      settle_timer   <= settle_timer_next;
      key_watch      <= key_watch_next;
      button_down    <= button_down_next;
      device_state   <= device_state_next;
      mic_enable_reg <= mic_enable_next;
      mic_bias_reg   <= mic_bias_next;
    end
  end

endmodule

// ===== design/headset_jack_and_hook_key_detect_unit.sv =====
// headset jack and hook key detector, one sample transaction per millisecond tick
//
// sample channel: jack detect, pole sense and hook key levels for one tick
// report channel: jack state, mic drive levels and switch / key reports,
//   exactly one report transaction for every sample transaction, in order
// cfg channel: five 16-bit delay registers in ticks, index 0..4, other
//   indexes ignored; always ready, write only while the block is idle
// latency: the report for a sample is valid on the cycle after it is taken
// throughput: one sample per cycle while report_ready is high, set by the single
//   pass of job timer, settle and priority logic between the state registers and
//   the report register
// stall: the report register holds while report_ready is low; a new sample
//   is taken in the same cycle the waiting report is taken
// reset: delays return to their defaults (20, 10, 600, 200, 200), all jobs
//   idle, no device, mic drive off, detect level taken as removed so a plug
//   present at start is seen as an insert edge on the first tick
module headset_jack_and_hook_key_detect_unit #(
  parameter int TIMER_WIDTH = hjd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  hjd_pkg::sample_t                      sample,
  output logic                                  report_valid,
  input  logic                                  report_ready,
  output hjd_pkg::report_t                      report,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hjd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [hjd_pkg::DELAY_WIDTH-1:0]       cfg_data
);
  import hjd_pkg::*;

  delays_t delays;
  report_t report_next;
  report_t report_q;
  logic    report_valid_q;
  logic    step;

  // take a sample whenever the report register is free or being drained
  assign sample_ready = !report_valid_q || report_ready;
  assign step         = sample_valid && sample_ready;
  assign cfg_ready    = 1'b1;

  // delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delays.detect_delay      <= DETECT_DELAY_RST;
      delays.pole_settle_delay <= SETTLE_DELAY_RST;
      delays.key_enable_delay  <= KEYEN_DELAY_RST;
      delays.press_delay       <= PRESS_DELAY_RST;
      delays.release_delay     <= RELEASE_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DETECT_DELAY:  delays.detect_delay      <= cfg_data;
        REG_SETTLE_DELAY:  delays.pole_settle_delay <= cfg_data;
        REG_KEYEN_DELAY:   delays.key_enable_delay  <= cfg_data;
        REG_PRESS_DELAY:   delays.press_delay       <= cfg_data;
        REG_RELEASE_DELAY: delays.release_delay     <= cfg_data;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // tick state and per-tick decision logic
  hjd_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (sample),
    .delays (delays),
    .report (report_next)
  );

  // report register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid_q <= 1'b0;
    end else if (step) begin
      report_valid_q <= 1'b1;
    end else if (report_ready) begin
      report_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      report_q <= report_next;
    end
  end

  assign report_valid = report_valid_q;
  assign report       = report_q;

endmodule

// ===== design/hjd_checker.sv =====
module hjd_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_ready,
  input logic             report_valid,
  input logic             report_ready,
  input hjd_pkg::report_t report
);
  import hjd_pkg::*;

  // a stalled report holds
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report))
    else $error("report changed while stalled");

  // nothing reported straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !report_valid)
    else $error("report valid after reset");

  // a free report slot always takes a sample
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !report_valid |-> sample_ready)
    else $error("sample refused with empty report register");

  // values only ride with their events, and the jack state is a valid code
  a_value_event: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> (!report.headphone_value || report.headphone_event) &&
                     (!report.mic_value || report.mic_event) &&
                     (!report.key_value || report.key_event) &&
                     (report.jack_state != 2'd3))
    else $error("report value without event or bad jack state");

  // a headset with mic keeps mic enable and bias on
  a_headset_drive: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.jack_state == JS_HEADSET |-> report.mic_enable && report.mic_bias)
    else $error("headset state without mic drive");

endmodule

bind headset_jack_and_hook_key_detect_unit hjd_checker u_hjd_checker (.*);
